FILE: rtl/swpc_pkg.sv
// Shared types and constants for the sine-wave pixel colour unit.
package swpc_pkg;

  localparam int FRAME_W = 16;
  localparam int PIXEL_W = 10;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 24;
  localparam int CYC_W   = 8;
  localparam int LEN_W   = 11;
  localparam int OFS_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [COLOR_W-1:0] BASE_COLOR_RST   = 24'h000000;
  localparam logic [COLOR_W-1:0] DEST_COLOR_RST   = 24'hFFFFFF;
  localparam logic [CYC_W-1:0]   WAVE_CYCLES_RST  = 8'd2;
  localparam logic [LEN_W-1:0]   STRIP_LENGTH_RST = 11'd1;
  localparam logic [OFS_W-1:0]   STRIP_OFFSET_RST = 10'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_COLOR   = 3'd0,
    REG_DEST_COLOR   = 3'd1,
    REG_WAVE_CYCLES  = 3'd2,
    REG_STRIP_LENGTH = 3'd3,
    REG_STRIP_OFFSET = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [PIXEL_W-1:0] pixel_index;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

endpackage

FILE: rtl/sine_wave_pixel_color_unit.sv
// Sine-wave colour gradient: phase reduction, sine lookup and colour blend pipeline.
//
// Usage:
//   item channel (item_valid / item_stall / item) carries a frame number and a
//   pixel index; color channel (color_valid / color_stall / color) returns one
//   red/green/blue transaction per input transaction, in order.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   only while no transaction is in flight. Unknown indexes are ignored.
// Throughput: one transaction per cycle, sustained while color_stall does not hold a waiting result.
// Pipeline: a restoring compare-subtract chain, 16 steps for the frame modulo,
//   MW = max(clog2(MAX_LEDS+1), 11) + 9 steps for the phase modulo and
//   SINE_TABLE_BITS steps for the table index, one step per stage.
// Reset: rst clears all valid bits and loads the register defaults
//   (base black, destination white, wave cycles two, length one, offset zero).
// Stall: when color_stall holds a waiting result the whole pipeline freezes
//   and item_stall is raised; the pipeline advances whenever no result waits.
module sine_wave_pixel_color_unit #(
  parameter int MAX_LEDS        = 1024,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  swpc_pkg::item_t       item,
  output logic                  color_valid,
  input  logic                  color_stall,
  output swpc_pkg::color_t      color,
  input  logic                  cfg_we,
  input  logic [swpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swpc_pkg::*;

  localparam int TB    = SINE_TABLE_BITS;
  localparam int LENW  = $clog2(MAX_LEDS + 1);
  localparam int SW    = ((LENW > LEN_W) ? LENW : LEN_W) + 1;
  localparam int MW    = SW + CYC_W;
  localparam int QLEN  = 1 << (TB - 2);
  localparam int QIW   = TB - 1;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [16:0] HALF_W  = 17'h08000;
  localparam logic [16:0] FULL_W  = 17'h10000;

  typedef logic [15:0] qtab_t [0:QLEN];

  // Quarter-wave table, Taylor series in Q2.30 rounded to Q1.15.
  function automatic qtab_t build_qtab();
    qtab_t              tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic               neg;
    int                 j;
    int                 n;
    for (j = 0; j <= QLEN; j++) begin
      x    = (PI_Q30 * 64'(j)) >> (TB - 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      neg  = 1'b1;
      for (n = 2; n <= 16; n += 2) begin
        term = (term * x2) >> 30;
        term = term / 64'(n * (n + 1));
        if (neg) sum = sum - signed'(term);
        else     sum = sum + signed'(term);
        neg = !neg;
      end
      if (sum < 0) sum = '0;
      if (sum > signed'(ONE_Q30)) sum = signed'(ONE_Q30);
      tab[j] = 16'((sum + 64'sd16384) >>> 15);
    end
    return tab;
  endfunction

  localparam qtab_t QSINE = build_qtab();

  function automatic logic [LENW-1:0] mod_step(logic [LENW-1:0] r, logic b,
                                               logic [LENW-1:0] d);
    logic [LENW:0] tmp;
    tmp = {r, b};
    if (tmp >= {1'b0, d}) tmp = tmp - {1'b0, d};
    return tmp[LENW-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] blend8(logic [CHAN_W-1:0] b,
                                               logic [CHAN_W-1:0] d,
                                               logic [16:0] t);
    logic [24:0] acc;
    acc = 25'(b) * 25'(FULL_W - t) + 25'(d) * 25'(t);
    return acc[23:16];
  endfunction

  // configuration registers
  logic [COLOR_W-1:0] base_color;
  logic [COLOR_W-1:0] dest_color;
  logic [CYC_W-1:0]   wave_cycles;
  logic [LEN_W-1:0]   strip_length;
  logic [OFS_W-1:0]   strip_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_color   <= BASE_COLOR_RST;
      dest_color   <= DEST_COLOR_RST;
      wave_cycles  <= WAVE_CYCLES_RST;
      strip_length <= STRIP_LENGTH_RST;
      strip_offset <= STRIP_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_COLOR:   base_color   <= cfg_data[COLOR_W-1:0];
        REG_DEST_COLOR:   dest_color   <= cfg_data[COLOR_W-1:0];
        REG_WAVE_CYCLES:  wave_cycles  <= cfg_data[CYC_W-1:0];
        REG_STRIP_LENGTH: strip_length <= cfg_data[LEN_W-1:0];
        REG_STRIP_OFFSET: strip_offset <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective divisor: zero reads as one, saturate at MAX_LEDS
  logic [LENW-1:0] len_eff;
  always_comb begin
    priority if (strip_length == '0) len_eff = LENW'(1);
    else if (32'(strip_length) > 32'(MAX_LEDS)) len_eff = LENW'(MAX_LEDS);
    else len_eff = LENW'(strip_length);
  end

  logic en;
  assign en         = !color_valid || !color_stall;
  assign item_stall = !en;

  // frame modulo length
  logic               a_vld [0:FRAME_W];
  logic [LENW-1:0]    a_rem [0:FRAME_W];
  logic [FRAME_W-1:0] a_div [0:FRAME_W];
  logic [PIXEL_W-1:0] a_pix [0:FRAME_W];

  assign a_vld[0] = item_valid;
  assign a_rem[0] = '0;
  assign a_div[0] = item.frame_number;
  assign a_pix[0] = item.pixel_index;

  for (genvar i = 0; i < FRAME_W; i++) begin : g_a
    always_ff @(posedge clk) begin
      if (rst) a_vld[i+1] <= 1'b0;
      else if (en) a_vld[i+1] <= a_vld[i];
      if (en) begin
        a_rem[i+1] <= mod_step(a_rem[i], a_div[i][FRAME_W-1], len_eff);
        a_div[i+1] <= {a_div[i][FRAME_W-2:0], 1'b0};
        a_pix[i+1] <= a_pix[i];
      end
    end
  end

  // offset add, then cycle multiply
  logic          b_vld;
  logic [SW-1:0] b_s;
  logic          c_vld [0:MW];
  logic [LENW-1:0] c_rem [0:MW];
  logic [MW-1:0] c_div [0:MW];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld    <= 1'b0;
      c_vld[0] <= 1'b0;
    end else if (en) begin
      b_vld    <= a_vld[FRAME_W];
      c_vld[0] <= b_vld;
    end
    if (en) begin
      b_s      <= SW'(a_rem[FRAME_W]) + SW'(strip_offset) + SW'(a_pix[FRAME_W]);
      c_div[0] <= MW'(b_s) * MW'(wave_cycles);
    end
  end

  assign c_rem[0] = '0;

  // product modulo length
  for (genvar i = 0; i < MW; i++) begin : g_c
    always_ff @(posedge clk) begin
      if (rst) c_vld[i+1] <= 1'b0;
      else if (en) c_vld[i+1] <= c_vld[i];
      if (en) begin
        c_rem[i+1] <= mod_step(c_rem[i], c_div[i][MW-1], len_eff);
        c_div[i+1] <= {c_div[i][MW-2:0], 1'b0};
      end
    end
  end

  // table index: (p << TB) / length, one quotient bit per stage
  logic            d_vld [0:TB];
  logic [LENW-1:0] d_rem [0:TB];
  logic [TB-1:0]   d_q   [0:TB];

  assign d_vld[0] = c_vld[MW];
  assign d_rem[0] = c_rem[MW];
  assign d_q[0]   = '0;

  for (genvar i = 0; i < TB; i++) begin : g_d
    logic [LENW:0] tmp;
    logic          qbit;
    assign tmp  = {d_rem[i], 1'b0};
    assign qbit = tmp >= {1'b0, len_eff};
    always_ff @(posedge clk) begin
      if (rst) d_vld[i+1] <= 1'b0;
      else if (en) d_vld[i+1] <= d_vld[i];
      if (en) begin
        d_rem[i+1] <= qbit ? LENW'(tmp - {1'b0, len_eff}) : tmp[LENW-1:0];
        d_q[i+1]   <= {d_q[i][TB-2:0], qbit};
      end
    end
  end

  // quadrant fold, table read, weight, blend
  logic [1:0]     quad;
  logic [TB-3:0]  qoff;
  assign quad = d_q[TB][TB-1:TB-2];
  assign qoff = d_q[TB][TB-3:0];

  logic           e_vld;
  logic [QIW-1:0] e_idx;
  logic           e_neg;
  logic           f_vld;
  logic [15:0]    f_sin;
  logic           f_neg;
  logic           g_vld;
  logic [16:0]    g_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld       <= 1'b0;
      f_vld       <= 1'b0;
      g_vld       <= 1'b0;
      color_valid <= 1'b0;
    end else if (en) begin
      e_vld       <= d_vld[TB];
      f_vld       <= e_vld;
      g_vld       <= f_vld;
      color_valid <= g_vld;
    end
    if (en) begin
      e_idx <= quad[0] ? QIW'(QLEN) - {1'b0, qoff} : {1'b0, qoff};
      e_neg <= quad[1];
      f_sin <= QSINE[e_idx];
      f_neg <= e_neg;
      g_t   <= f_neg ? HALF_W - {1'b0, f_sin} : HALF_W + {1'b0, f_sin};
      color.red   <= blend8(base_color[23:16], dest_color[23:16], g_t);
      color.green <= blend8(base_color[15:8],  dest_color[15:8],  g_t);
      color.blue  <= blend8(base_color[7:0],   dest_color[7:0],   g_t);
    end
  end

endmodule
